@@ src/rmts_pkg.sv @@
// ----------------------------------------------------------------------------
// rmts_pkg: shared types and constants
// Slot entry layout, operation, status and task state codes, sizes.
// ----------------------------------------------------------------------------
package rmts_pkg;

  localparam int TASK_SLOTS = 16;
  localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_W      = $clog2(TASK_SLOTS + 1);

  localparam int PID_W    = 22;
  localparam int PER_W    = 16;
  localparam int COST_W   = 16;
  localparam int LOAD_W   = 10;
  localparam int TIME_W   = 48;
  localparam int STATUS_W = 3;
  localparam int FUNC_W   = 2;
  localparam int TST_W    = 2;

  // 1000 * cost fits in this many bits
  localparam int SCALED_W = 26;
  localparam int DIV_CNT_W = $clog2(TIME_W + 1);

  localparam logic [LOAD_W-1:0] LOAD_SCALE  = 10'd1000;
  localparam logic [LOAD_W-1:0] ADMIT_RESET = 10'd693;

  // operations
  localparam logic [FUNC_W-1:0] FN_REGISTER   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_YIELD      = 2'd1;
  localparam logic [FUNC_W-1:0] FN_DEREGISTER = 2'd2;
  localparam logic [FUNC_W-1:0] FN_TICK       = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_LOAD      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUP       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BAD_PER   = 3'd5;

  // task states
  localparam logic [TST_W-1:0] TS_RUN   = 2'd0;
  localparam logic [TST_W-1:0] TS_READY = 2'd1;
  localparam logic [TST_W-1:0] TS_SLEEP = 2'd2;

  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic [PER_W-1:0]  period;
    logic [LOAD_W-1:0] load;
    logic [TST_W-1:0]  tstate;
    logic              released;
    logic [TIME_W-1:0] next_release;
  } entry_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                run_valid;
    logic [PID_W-1:0]    run_pid;
    logic                switched;
    logic [LOAD_W-1:0]   load_total;
  } result_t;

endpackage

@@ src/rmts_divider.sv @@
// ----------------------------------------------------------------------------
// rmts_divider: iterative restoring divider
// One quotient bit per cycle; 48-bit dividend by 16-bit divisor.
// ----------------------------------------------------------------------------
module rmts_divider (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [rmts_pkg::TIME_W-1:0]    dividend,
  input  logic [rmts_pkg::PER_W-1:0]     divisor,
  output logic                           done,
  output logic [rmts_pkg::TIME_W-1:0]    quot,
  output logic [rmts_pkg::PER_W-1:0]     rem
);

  logic [rmts_pkg::DIV_CNT_W-1:0] cnt;
  logic [rmts_pkg::PER_W-1:0]     dvs;
  logic [rmts_pkg::PER_W:0]       trial;
  logic                           fits;

  // shifted partial remainder and compare
  assign trial = {rem, quot[rmts_pkg::TIME_W-1]};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      // done pulses on the last quotient bit
      done <= !start && (cnt == rmts_pkg::DIV_CNT_W'(1));
      if (start) begin
        cnt  <= rmts_pkg::DIV_CNT_W'(rmts_pkg::TIME_W);
        quot <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        quot <= {quot[rmts_pkg::TIME_W-2:0], fits};
        rem  <= fits ? rmts_pkg::PER_W'(trial - {1'b0, dvs})
                     : trial[rmts_pkg::PER_W-1:0];
      end
    end
  end

endmodule

@@ src/rmts_core.sv @@
// ----------------------------------------------------------------------------
// rmts_core: slot table memory and operation sequencer
// Scans the slot memory for match, free slot and wakeups, applies the
// operation, then scans again to dispatch the highest priority task.
// ----------------------------------------------------------------------------
module rmts_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [rmts_pkg::FUNC_W-1:0]      func,
  input  logic [rmts_pkg::PID_W-1:0]       pid,
  input  logic [rmts_pkg::PER_W-1:0]       period_ms,
  input  logic [rmts_pkg::COST_W-1:0]      cost_ms,
  input  logic [rmts_pkg::LOAD_W-1:0]      admit_limit,
  output logic                             idle,
  output logic                             res_valid,
  input  logic                             res_take,
  output rmts_pkg::result_t                res
);

  localparam int N = rmts_pkg::TASK_SLOTS;
  localparam int SW = rmts_pkg::SLOT_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_OP     = 4'd2;
  localparam logic [3:0] S_DIV    = 4'd3;
  localparam logic [3:0] S_DISP   = 4'd4;
  localparam logic [3:0] S_DECIDE = 4'd5;
  localparam logic [3:0] S_WR2    = 4'd6;
  localparam logic [3:0] S_DONE   = 4'd7;

  logic [3:0] st;
  logic [rmts_pkg::CNT_W-1:0] sc;
  logic p_vld;
  logic [SW-1:0] p_idx;

  // latched transaction
  logic [rmts_pkg::FUNC_W-1:0] op_func;
  logic [rmts_pkg::PID_W-1:0]  op_pid;
  logic [rmts_pkg::PER_W-1:0]  op_period;
  logic [rmts_pkg::COST_W-1:0] op_cost;

  // global state
  logic [rmts_pkg::TIME_W-1:0] now;
  logic [rmts_pkg::LOAD_W-1:0] total;
  logic [N-1:0] used;
  logic [N-1:0] armed;
  logic run_valid;
  logic [SW-1:0] run_slot;
  logic [rmts_pkg::PID_W-1:0] run_pid;

  // scan results
  logic match_found, free_found, best_found;
  logic [SW-1:0] match_idx, free_idx, best_idx;
  rmts_pkg::entry_t match_ent, best_ent, run_ent;
  logic [rmts_pkg::STATUS_W-1:0] status;
  logic switched;

  // slot memory
  rmts_pkg::entry_t mem [N];
  rmts_pkg::entry_t mem_rdata, mem_wdata;
  logic mem_we;
  logic [SW-1:0] mem_waddr, mem_raddr;

  // divider
  logic div_start, div_done;
  logic [rmts_pkg::TIME_W-1:0] div_dvd, div_quot;
  logic [rmts_pkg::PER_W-1:0]  div_dvs, div_rem;

  logic [rmts_pkg::SCALED_W-1:0] scaled;
  logic wake_hit;
  logic [rmts_pkg::SCALED_W:0] load_w;
  logic [rmts_pkg::SCALED_W+1:0] load_sum;
  logic admit;
  logic [rmts_pkg::TIME_W-1:0] new_release;
  logic preempt;

  assign mem_raddr = sc[SW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  rmts_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // datapath terms
  assign scaled   = rmts_pkg::SCALED_W'(op_cost) *
                    rmts_pkg::SCALED_W'(rmts_pkg::LOAD_SCALE);
  assign wake_hit = used[p_idx] && armed[p_idx] && (mem_rdata.next_release <= now);
  assign load_w   = div_quot[rmts_pkg::SCALED_W:0] + 1'b1;
  assign load_sum = {1'b0, load_w} + (rmts_pkg::SCALED_W+2)'(total);
  assign admit    = (load_sum <= (rmts_pkg::SCALED_W+2)'(admit_limit));
  assign new_release = now - rmts_pkg::TIME_W'(div_rem)
                       + rmts_pkg::TIME_W'(match_ent.period);
  assign preempt  = (run_ent.period > best_ent.period);

  // divider operands
  always_comb begin
    div_start = 1'b0;
    div_dvd   = rmts_pkg::TIME_W'(scaled);
    div_dvs   = op_period;
    if (op_func == rmts_pkg::FN_YIELD) begin
      div_dvd = now - match_ent.next_release;
      div_dvs = match_ent.period;
    end
    if (st == S_OP) begin
      case (op_func)
        rmts_pkg::FN_REGISTER:
          div_start = (op_period != '0) && !match_found && free_found;
        rmts_pkg::FN_YIELD:
          div_start = match_found && match_ent.released &&
                      (match_ent.next_release <= now);
        default: div_start = 1'b0;
      endcase
    end
  end

  // memory write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = p_idx;
    mem_wdata = mem_rdata;
    case (st)
      S_SCAN: begin
        if (p_vld && op_func == rmts_pkg::FN_TICK && wake_hit) begin
          mem_we           = 1'b1;
          mem_wdata.tstate = rmts_pkg::TS_READY;
        end
      end
      S_OP: begin
        mem_waddr        = match_idx;
        mem_wdata        = match_ent;
        mem_wdata.tstate = rmts_pkg::TS_SLEEP;
        if (op_func == rmts_pkg::FN_YIELD && match_found) begin
          if (!match_ent.released) begin
            mem_we                 = 1'b1;
            mem_wdata.released     = 1'b1;
            mem_wdata.next_release = now;
          end else if (match_ent.next_release > now) begin
            mem_we = 1'b1;
          end
        end
      end
      S_DIV: begin
        if (op_func == rmts_pkg::FN_REGISTER) begin
          mem_waddr              = free_idx;
          mem_wdata.pid          = op_pid;
          mem_wdata.period       = op_period;
          mem_wdata.load         = load_w[rmts_pkg::LOAD_W-1:0];
          mem_wdata.tstate       = rmts_pkg::TS_SLEEP;
          mem_wdata.released     = 1'b0;
          mem_wdata.next_release = '0;
          mem_we                 = div_done && admit;
        end else begin
          mem_waddr              = match_idx;
          mem_wdata              = match_ent;
          mem_wdata.tstate       = rmts_pkg::TS_SLEEP;
          mem_wdata.next_release = new_release;
          mem_we                 = div_done;
        end
      end
      S_DECIDE: begin
        if (best_found && !run_valid) begin
          mem_we           = 1'b1;
          mem_waddr        = best_idx;
          mem_wdata        = best_ent;
          mem_wdata.tstate = rmts_pkg::TS_RUN;
        end else if (best_found && preempt) begin
          mem_we           = 1'b1;
          mem_waddr        = run_slot;
          mem_wdata        = run_ent;
          mem_wdata.tstate = rmts_pkg::TS_READY;
        end
      end
      S_WR2: begin
        mem_we           = 1'b1;
        mem_waddr        = best_idx;
        mem_wdata        = best_ent;
        mem_wdata.tstate = rmts_pkg::TS_RUN;
      end
      default: mem_we = 1'b0;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      sc        <= '0;
      p_vld     <= 1'b0;
      now       <= '0;
      total     <= '0;
      used      <= '0;
      armed     <= '0;
      run_valid <= 1'b0;
    end else begin
      case (st)
        S_IDLE: begin
          if (start) begin
            op_func     <= func;
            op_pid      <= pid;
            op_period   <= period_ms;
            op_cost     <= cost_ms;
            match_found <= 1'b0;
            free_found  <= 1'b0;
            status      <= rmts_pkg::ST_OK;
            switched    <= 1'b0;
            sc          <= '0;
            p_vld       <= 1'b0;
            if (func == rmts_pkg::FN_TICK) begin
              now <= now + 1'b1;
            end
            st <= S_SCAN;
          end
        end
        S_SCAN, S_DISP: begin
          // issue next read, process the previous one
          p_vld <= (sc < rmts_pkg::CNT_W'(N));
          p_idx <= sc[SW-1:0];
          sc    <= sc + 1'b1;
          if (p_vld) begin
            if (st == S_SCAN) begin
              if (used[p_idx] && mem_rdata.pid == op_pid && !match_found) begin
                match_found <= 1'b1;
                match_idx   <= p_idx;
                match_ent   <= mem_rdata;
              end
              if (!used[p_idx] && !free_found) begin
                free_found <= 1'b1;
                free_idx   <= p_idx;
              end
              if (op_func == rmts_pkg::FN_TICK && wake_hit) begin
                armed[p_idx] <= 1'b0;
              end
            end else begin
              if (used[p_idx] && mem_rdata.tstate == rmts_pkg::TS_READY &&
                  (!best_found || mem_rdata.period < best_ent.period)) begin
                best_found <= 1'b1;
                best_idx   <= p_idx;
                best_ent   <= mem_rdata;
              end
              if (run_valid && p_idx == run_slot) begin
                run_ent <= mem_rdata;
              end
            end
          end
          if (sc == rmts_pkg::CNT_W'(N)) begin
            st <= (st == S_SCAN) ? S_OP : S_DECIDE;
          end
        end
        S_OP: begin
          sc         <= '0;
          p_vld      <= 1'b0;
          best_found <= 1'b0;
          // the divider runs exactly when the operation needs a quotient
          st         <= div_start ? S_DIV : S_DISP;
          case (op_func)
            rmts_pkg::FN_REGISTER: begin
              if (op_period == '0) begin
                status <= rmts_pkg::ST_BAD_PER;
              end else if (match_found) begin
                status <= rmts_pkg::ST_DUP;
              end else if (!free_found) begin
                status <= rmts_pkg::ST_FULL;
              end
            end
            rmts_pkg::FN_YIELD: begin
              if (!match_found) begin
                status <= rmts_pkg::ST_NOT_FOUND;
              end else begin
                armed[match_idx] <= 1'b1;
                if (run_valid && run_slot == match_idx) begin
                  run_valid <= 1'b0;
                end
              end
            end
            rmts_pkg::FN_DEREGISTER: begin
              if (!match_found) begin
                status <= rmts_pkg::ST_NOT_FOUND;
              end else begin
                total <= (total >= match_ent.load) ? total - match_ent.load : '0;
                used[match_idx]  <= 1'b0;
                armed[match_idx] <= 1'b0;
                if (run_valid && run_slot == match_idx) begin
                  run_valid <= 1'b0;
                end
              end
            end
            default: ;
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            st <= S_DISP;
            if (op_func == rmts_pkg::FN_REGISTER) begin
              if (admit) begin
                used[free_idx]  <= 1'b1;
                armed[free_idx] <= 1'b0;
                total <= total + load_w[rmts_pkg::LOAD_W-1:0];
              end else begin
                status <= rmts_pkg::ST_LOAD;
              end
            end
          end
        end
        S_DECIDE: begin
          // a preemption needs a second write for the new running task
          st <= (best_found && run_valid && preempt) ? S_WR2 : S_DONE;
          if (best_found && !run_valid) begin
            run_valid <= 1'b1;
            run_slot  <= best_idx;
            run_pid   <= best_ent.pid;
            switched  <= 1'b1;
          end else if (best_found && preempt) begin
            run_slot <= best_idx;
            run_pid  <= best_ent.pid;
            switched <= 1'b1;
          end
        end
        S_WR2: st <= S_DONE;
        S_DONE: begin
          if (res_take) begin
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  assign idle          = (st == S_IDLE);
  assign res_valid     = (st == S_DONE);
  assign res.status     = status;
  assign res.run_valid  = run_valid;
  assign res.run_pid    = run_valid ? run_pid : '0;
  assign res.switched   = switched;
  assign res.load_total = total;

endmodule

@@ src/rate_monotonic_task_scheduler.sv @@
// A transaction passes a sweep of the slot memory, the operation, a second sweep
// for dispatch and the result stage; a preemption adds a second slot write, and
// register or a catching-up yield also runs the bit-serial divider. A new
// transaction is taken only once the core is idle again after its result.
// Reset (synchronous, active high) empties the task table, clears time, total
// load and the running task, and sets admit_limit to 693.
// ----------------------------------------------------------------------------
// rate_monotonic_task_scheduler: rate-monotonic scheduler, admission control
// Configuration register, input handshake and registered result stage.
// ----------------------------------------------------------------------------
module rate_monotonic_task_scheduler (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [rmts_pkg::LOAD_W-1:0]        cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [rmts_pkg::FUNC_W-1:0]        func,
  input  logic [rmts_pkg::PID_W-1:0]         pid,
  input  logic [rmts_pkg::PER_W-1:0]         period_ms,
  input  logic [rmts_pkg::COST_W-1:0]        cost_ms,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [rmts_pkg::STATUS_W-1:0]      status,
  output logic                               run_valid,
  output logic [rmts_pkg::PID_W-1:0]         run_pid,
  output logic                               switched,
  output logic [rmts_pkg::LOAD_W-1:0]        load_total
);

  logic [rmts_pkg::LOAD_W-1:0] admit_limit;
  logic core_idle, res_valid, res_take;
  rmts_pkg::result_t res;

  // admission limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      admit_limit <= rmts_pkg::ADMIT_RESET;
    end else if (cfg_wr_en) begin
      admit_limit <= cfg_wr_data;
    end
  end

  assign in_ready = core_idle;
  assign res_take = res_valid && (!out_valid || out_ready);

  rmts_core u_core (
    .clk         (clk),
    .rst         (rst),
    .start       (in_valid && core_idle),
    .func        (func),
    .pid         (pid),
    .period_ms   (period_ms),
    .cost_ms     (cost_ms),
    .admit_limit (admit_limit),
    .idle        (core_idle),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res         (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      status     <= res.status;
      run_valid  <= res.run_valid;
      run_pid    <= res.run_pid;
      switched   <= res.switched;
      load_total <= res.load_total;
    end
  end

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// Testbench for rate_monotonic_task_scheduler
// A queue-fed driver offers register, yield, deregister and tick
// transactions in random bursts. A clocked monitor predicts each accepted
// transaction and checks every result against the oldest prediction while
// the receiver stalls on a pattern of its own. The admit limit moves
// through several values, the extremes among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int NSLOT       = rmts_pkg::TASK_SLOTS;
  localparam int FUNC_W      = rmts_pkg::FUNC_W;
  localparam int PID_W       = rmts_pkg::PID_W;
  localparam int PER_W       = rmts_pkg::PER_W;
  localparam int COST_W      = rmts_pkg::COST_W;
  localparam int LOAD_W      = rmts_pkg::LOAD_W;
  localparam int STATUS_W    = rmts_pkg::STATUS_W;
  localparam int TST_W       = rmts_pkg::TST_W;
  localparam int TIME_W      = rmts_pkg::TIME_W;
  localparam int DRAIN_WAIT  = 120;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int POOL_N      = 20;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [PID_W-1:0]  pid;
    logic [PER_W-1:0]  period;
    logic [COST_W-1:0] cost;
  } op_t;

  logic clk, rst;
  logic cfg_wr_en;
  logic [LOAD_W-1:0] cfg_wr_data;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [FUNC_W-1:0] func;
  logic [PID_W-1:0] pid;
  logic [PER_W-1:0] period_ms;
  logic [COST_W-1:0] cost_ms;
  logic [STATUS_W-1:0] status;
  logic run_valid, switched;
  logic [PID_W-1:0] run_pid;
  logic [LOAD_W-1:0] load_total;

  rate_monotonic_task_scheduler DUT (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .pid(pid), .period_ms(period_ms), .cost_ms(cost_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .run_valid(run_valid), .run_pid(run_pid),
    .switched(switched), .load_total(load_total)
  );

  op_t               pending_ops[$];
  rmts_pkg::result_t sched_expect[$];
  int      fails = 0;
  int      rx_count = 0;
  int      cycles = 0;
  logic    in_fire;
  logic [PID_W-1:0] pid_pool[POOL_N];

  // scheduler shadow state
  bit                sh_used[NSLOT];
  logic [PID_W-1:0]  sh_pid[NSLOT];
  logic [PER_W-1:0]  sh_per[NSLOT];
  int unsigned       sh_load[NSLOT];
  logic [TST_W-1:0]  sh_tst[NSLOT];
  bit                sh_rel[NSLOT];
  bit                sh_armed[NSLOT];
  logic [TIME_W-1:0] sh_next[NSLOT];
  logic [TIME_W-1:0] sh_now;
  int unsigned       sh_total;
  bit                sh_run_v;
  int                sh_run_s;
  int unsigned       sh_limit;

  function automatic int find_task(logic [PID_W-1:0] p);
    for (int i = 0; i < NSLOT; i++)
      if (sh_used[i] && sh_pid[i] == p) return i;
    return -1;
  endfunction

  function automatic logic [STATUS_W-1:0] admit_task(op_t t);
    int s;
    int free_s;
    int unsigned ld;
    s = find_task(t.pid);
    free_s = -1;
    if (t.period == 0) return rmts_pkg::ST_BAD_PER;
    if (s >= 0) return rmts_pkg::ST_DUP;
    for (int i = NSLOT - 1; i >= 0; i--)
      if (!sh_used[i]) free_s = i;
    if (free_s < 0) return rmts_pkg::ST_FULL;
    ld = (1000 * int'(t.cost)) / int'(t.period) + 1;
    if (ld + sh_total > sh_limit) return rmts_pkg::ST_LOAD;
    sh_used[free_s] = 1;
    sh_pid[free_s] = t.pid;
    sh_per[free_s] = t.period;
    sh_load[free_s] = ld;
    sh_tst[free_s] = rmts_pkg::TS_SLEEP;
    sh_rel[free_s] = 0;
    sh_armed[free_s] = 0;
    sh_next[free_s] = '0;
    sh_total += ld;
    return rmts_pkg::ST_OK;
  endfunction

  function automatic logic [STATUS_W-1:0] yield_task(logic [PID_W-1:0] p);
    int s;
    longint unsigned k, per;
    s = find_task(p);
    if (s < 0) return rmts_pkg::ST_NOT_FOUND;
    sh_tst[s] = rmts_pkg::TS_SLEEP;
    if (sh_run_v && sh_run_s == s) sh_run_v = 0;
    if (!sh_rel[s]) begin
      sh_next[s] = sh_now;
      sh_rel[s] = 1;
    end else if (sh_next[s] <= sh_now) begin
      per = sh_per[s];
      k = (64'(sh_now) - 64'(sh_next[s])) / per + 1;
      sh_next[s] = TIME_W'(64'(sh_next[s]) + k * per);
    end
    sh_armed[s] = 1;
    return rmts_pkg::ST_OK;
  endfunction

  function automatic logic [STATUS_W-1:0] drop_task(logic [PID_W-1:0] p);
    int s;
    s = find_task(p);
    if (s < 0) return rmts_pkg::ST_NOT_FOUND;
    sh_total = (sh_total >= sh_load[s]) ? sh_total - sh_load[s] : 0;
    sh_used[s] = 0;
    sh_armed[s] = 0;
    if (sh_run_v && sh_run_s == s) sh_run_v = 0;
    return rmts_pkg::ST_OK;
  endfunction

  // compute the scheduler result for one accepted transaction
  function automatic rmts_pkg::result_t schedule_op(op_t t);
    rmts_pkg::result_t r;
    int best;
    bit sw;
    best = -1;
    sw = 0;
    r.status = rmts_pkg::ST_OK;
    case (t.func)
      rmts_pkg::FN_REGISTER:   r.status = admit_task(t);
      rmts_pkg::FN_YIELD:      r.status = yield_task(t.pid);
      rmts_pkg::FN_DEREGISTER: r.status = drop_task(t.pid);
      default: begin
        sh_now = sh_now + 1'b1;
        for (int i = 0; i < NSLOT; i++)
          if (sh_used[i] && sh_armed[i] && sh_next[i] <= sh_now) begin
            sh_tst[i] = rmts_pkg::TS_READY;
            sh_armed[i] = 0;
          end
      end
    endcase
    // dispatch: shortest period wins, lowest slot on ties
    for (int i = 0; i < NSLOT; i++)
      if (sh_used[i] && sh_tst[i] == rmts_pkg::TS_READY &&
          (best < 0 || sh_per[i] < sh_per[best]))
        best = i;
    if (best >= 0) begin
      if (!sh_run_v) begin
        sh_tst[best] = rmts_pkg::TS_RUN;
        sh_run_s = best;
        sh_run_v = 1;
        sw = 1;
      end else if (sh_per[sh_run_s] > sh_per[best]) begin
        sh_tst[sh_run_s] = rmts_pkg::TS_READY;
        sh_tst[best] = rmts_pkg::TS_RUN;
        sh_run_s = best;
        sw = 1;
      end
    end
    r.run_valid = sh_run_v;
    r.run_pid = sh_run_v ? sh_pid[sh_run_s] : '0;
    r.switched = sw;
    r.load_total = LOAD_W'(sh_total);
    return r;
  endfunction

  function automatic op_t mk_op(logic [FUNC_W-1:0] f, logic [PID_W-1:0] p,
                                logic [PER_W-1:0] per, logic [COST_W-1:0] c);
    op_t t;
    t.func = f; t.pid = p; t.period = per; t.cost = c;
    return t;
  endfunction

  function automatic logic [PID_W-1:0] pick_pid();
    if ($urandom_range(0, 9) < 9) return pid_pool[$urandom_range(0, POOL_N - 1)];
    return PID_W'($urandom);
  endfunction

  function automatic op_t rand_op();
    op_t t;
    int r;
    r = $urandom_range(0, 99);
    t.pid = pick_pid();
    t.period = PER_W'($urandom);
    t.cost = COST_W'($urandom);
    if (r < 35) t.func = rmts_pkg::FN_TICK;
    else if (r < 62) begin
      t.func = rmts_pkg::FN_REGISTER;
      case ($urandom_range(0, 19))
        0: t.period = '0;
        1: t.period = '1;
        2: ;
        default: t.period = PER_W'($urandom_range(1, 40));
      endcase
      if ($urandom_range(0, 9) != 0) t.cost = COST_W'($urandom_range(0, t.period / 3));
    end else if (r < 87) t.func = rmts_pkg::FN_YIELD;
    else t.func = rmts_pkg::FN_DEREGISTER;
    return t;
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // driver: bursts of transactions separated by random gaps
  int burst_left = 0, gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (in_valid && !in_fire) begin
      in_valid <= 1;
    end else if (gap_left > 0) begin
      in_valid <= 0;
      gap_left <= gap_left - 1;
    end else if (pending_ops.size() > 0) begin
      op_t t;
      t = pending_ops.pop_front();
      func <= t.func; pid <= t.pid; period_ms <= t.period; cost_ms <= t.cost;
      in_valid <= 1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 0;
    end
  end

  // receiver: stall pattern plus one long hold-off
  int rx_mode = 0, rx_mode_left = 0, hold_left = 0;
  bit long_hold_done = 0;
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else if (hold_left > 0) begin
      out_ready <= 0;
      hold_left <= hold_left - 1;
    end else if (!long_hold_done && rx_count >= 600) begin
      out_ready <= 0;
      hold_left <= 3000;
      long_hold_done <= 1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode <= $urandom_range(0, 2);
        rx_mode_left <= $urandom_range(20, 200);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        0: out_ready <= 1;
        1: out_ready <= $urandom_range(0, 1);
        default: out_ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // monitor: predict accepted transactions, check results
  always @(posedge clk) begin
    rmts_pkg::result_t got, want;
    if (rst) begin
      in_fire <= 0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (in_valid && in_ready)
        sched_expect.push_back(schedule_op(mk_op(func, pid, period_ms, cost_ms)));
      if (out_valid && out_ready) begin
        rx_count <= rx_count + 1;
        got.status = status; got.run_valid = run_valid; got.run_pid = run_pid;
        got.switched = switched; got.load_total = load_total;
        if (sched_expect.size() == 0) begin
          $error("unexpected result transaction");
          fails++;
        end else begin
          want = sched_expect.pop_front();
          if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status); fails++;
          end
          if (got.run_valid !== want.run_valid) begin
            $error("run_valid expected %0d actual %0d", want.run_valid, got.run_valid); fails++;
          end
          if (got.run_pid !== want.run_pid) begin
            $error("run_pid expected %0d actual %0d", want.run_pid, got.run_pid); fails++;
          end
          if (got.switched !== want.switched) begin
            $error("switched expected %0d actual %0d", want.switched, got.switched); fails++;
          end
          if (got.load_total !== want.load_total) begin
            $error("load_total expected %0d actual %0d", want.load_total, got.load_total);
            fails++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_ops.size() > 0 || in_valid || sched_expect.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_limit(logic [LOAD_W-1:0] v);
    @(negedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    sh_limit = v;
    @(negedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic add_random(int n);
    for (int i = 0; i < n; i++) pending_ops.push_back(rand_op());
  endtask

  // sequencing of phases
  initial begin
    rst = 1;
    cfg_wr_en = 0;
    cfg_wr_data = '0;
    in_valid = 0;
    out_ready = 0;
    func = '0; pid = '0; period_ms = '0; cost_ms = '0;
    sh_limit = rmts_pkg::ADMIT_RESET;
    sh_now = '0; sh_total = 0; sh_run_v = 0; sh_run_s = 0;
    for (int i = 0; i < NSLOT; i++) begin
      sh_used[i] = 0; sh_armed[i] = 0; sh_rel[i] = 0; sh_pid[i] = '0;
      sh_per[i] = '0; sh_load[i] = 0; sh_tst[i] = '0; sh_next[i] = '0;
    end
    pid_pool[0] = '0;
    pid_pool[1] = '1;
    for (int i = 2; i < POOL_N; i++) pid_pool[i] = PID_W'($urandom);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: refusals, first yield, wakeup, preemption, unknown pid
    set_limit(10'd693);
    pending_ops.push_back(mk_op(rmts_pkg::FN_REGISTER, 22'd5, 16'd0, 16'd1));
    pending_ops.push_back(mk_op(rmts_pkg::FN_REGISTER, '0, 16'd10, 16'd1));
    pending_ops.push_back(mk_op(rmts_pkg::FN_REGISTER, '0, 16'd20, 16'd1));
    pending_ops.push_back(mk_op(rmts_pkg::FN_REGISTER, '1, '1, '1));
    pending_ops.push_back(mk_op(rmts_pkg::FN_REGISTER, '1, 16'd1, '1));
    pending_ops.push_back(mk_op(rmts_pkg::FN_YIELD, '0, '0, '0));
    pending_ops.push_back(mk_op(rmts_pkg::FN_TICK, '0, '0, '0));
    pending_ops.push_back(mk_op(rmts_pkg::FN_YIELD, 22'h2aaaaa, '0, '0));
    pending_ops.push_back(mk_op(rmts_pkg::FN_DEREGISTER, 22'h155555, '0, '0));
    pending_ops.push_back(mk_op(rmts_pkg::FN_REGISTER, '1, 16'd5, 16'd0));
    pending_ops.push_back(mk_op(rmts_pkg::FN_YIELD, '1, '0, '0));
    pending_ops.push_back(mk_op(rmts_pkg::FN_TICK, '0, '0, '0));
    pending_ops.push_back(mk_op(rmts_pkg::FN_YIELD, '1, '0, '0));
    for (int i = 0; i < 7; i++)
      pending_ops.push_back(mk_op(rmts_pkg::FN_TICK, '0, '0, '0));
    pending_ops.push_back(mk_op(rmts_pkg::FN_YIELD, '0, '0, '0));
    pending_ops.push_back(mk_op(rmts_pkg::FN_DEREGISTER, '0, '0, '0));
    pending_ops.push_back(mk_op(rmts_pkg::FN_DEREGISTER, '1, '0, '0));
    wait_idle();

    // full limit: fill the table with zero-cost tasks, then one more
    set_limit(10'd1000);
    for (int i = 0; i < NSLOT + 1; i++)
      pending_ops.push_back(mk_op(rmts_pkg::FN_REGISTER, PID_W'(1000 + i),
                                  PER_W'(i + 1), '0));
    for (int i = 0; i < NSLOT; i++)
      pending_ops.push_back(mk_op(rmts_pkg::FN_DEREGISTER, PID_W'(1000 + i), '0, '0));
    add_random(300);
    wait_idle();

    // zero limit: no registration is admitted
    set_limit(10'd0);
    add_random(150);
    wait_idle();

    set_limit(LOAD_W'($urandom_range(0, 1000)));
    add_random(400);
    wait_idle();

    set_limit(10'd1000);
    add_random(400);
    wait_idle();

    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
